// ----- rtl/pooled_value_list_table_core_assert.svh -----
// assertion macros shared by the checker
`ifndef POOLED_VALUE_LIST_TABLE_CORE_ASSERT_SVH
`define POOLED_VALUE_LIST_TABLE_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define PVLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define PVLT_NEVER(lbl, cond, msg) \
  `PVLT_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/pvlt_pkg.sv -----
package pvlt_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } pvlt_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } pvlt_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESULT
  } pvlt_state_e;

  typedef struct packed {
    pvlt_status_e           status;
    logic [OCC_W-1:0]       occupancy;
  } pvlt_res_t;

endpackage

// ----- rtl/pvlt_ram.sv -----
module pvlt_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pvlt_ctrl.sv -----
module pvlt_ctrl import pvlt_pkg::*; #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int unsigned CW     = $clog2(SLOTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pvlt_op_e          op_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pvlt_res_t         res_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [DATA_W:0]   ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [DATA_W:0]   ram_rdata_i
);

  pvlt_state_e       state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  pvlt_op_e          op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              found_q, found_d;
  pvlt_status_e      status_q, status_d;

  logic              last_idx;
  logic              is_full;
  logic              is_empty;
  logic              rd_used;
  logic [DATA_W-1:0] rd_data;
  logic              rd_match;

  assign last_idx = (idx_q == AW'(SLOTS - 1));
  assign is_full  = (count_q == CW'(SLOTS));
  assign is_empty = (count_q == '0);
  assign rd_used  = ram_rdata_i[DATA_W];
  assign rd_data  = ram_rdata_i[DATA_W-1:0];
  assign rd_match = rd_used && (rd_data == val_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (last_idx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if ((op_i == OP_INSERT && is_full) || (op_i == OP_REMOVE && is_empty)) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((op_q == OP_INSERT && !rd_used) || last_idx) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    op_d        = op_q;
    val_d       = val_q;
    found_d     = found_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = AW'(idx_q + AW'(1));
    case (state_q)
      S_CLEAR: begin
        ram_we_o = 1'b1;
        idx_d    = last_idx ? '0 : AW'(idx_q + AW'(1));
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_i;
          val_d   = value_i;
          found_d = 1'b0;
          idx_d   = '0;
          if (op_i == OP_INSERT && is_full) begin
            status_d = ST_FULL;
          end else if (op_i == OP_REMOVE && is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = '0;
          end
        end
      end
      S_SCAN: begin
        if (op_q == OP_INSERT) begin
          if (!rd_used) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = {1'b1, val_q};
            count_d     = CW'(count_q + CW'(1));
            status_d    = ST_OK;
          end else if (last_idx) begin
            status_d = ST_FULL;
          end else begin
            ram_re_o = 1'b1;
            idx_d    = AW'(idx_q + AW'(1));
          end
        end else begin
          if (rd_match) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = {1'b0, rd_data};
            count_d     = CW'(count_q - CW'(1));
            found_d     = 1'b1;
          end
          if (last_idx) begin
            status_d = (found_q || rd_match) ? ST_OK : ST_NOT_FOUND;
          end else begin
            ram_re_o = 1'b1;
            idx_d    = AW'(idx_q + AW'(1));
          end
        end
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o.status    = status_q;
  assign res_o.occupancy = OCC_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      count_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    status_q <= status_d;
  end

endmodule

// ----- rtl/pvlt_out.sv -----
module pvlt_out import pvlt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  pvlt_res_t        res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [OCC_W-1:0] occupancy_o
);

  logic      out_valid_q, out_valid_d;
  pvlt_res_t res_q;
  logic      load;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign occupancy_o = res_q.occupancy;

endmodule

// ----- rtl/pooled_value_list_table_core.sv -----
// Pool of SLOTS data words with one valid bit each, held together in a single RAM.
// Insert stores the low DATA_BYTES*8 bits (at most 32) of value in the lowest free
// slot; remove frees every occupied slot holding that word. After reset a clearing
// pass writes every slot free, with in_ready_o low. One item is handled at a time:
// an insert walks the slots from slot 0 up to the lowest free one, a remove walks
// every slot, and an insert into a full pool or a remove from an empty one goes
// straight to its result with no walk. The slot walk does one RAM read per cycle.
// Occupancy is the low 5 bits of the slot count.
module pooled_value_list_table_core import pvlt_pkg::*; #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DATA_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [OCC_W-1:0]   occupancy_o
);

  localparam int unsigned DATA_W = (DATA_BYTES * 8 > VALUE_W) ? VALUE_W : DATA_BYTES * 8;
  localparam int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW     = $clog2(SLOTS + 1);

  logic              res_valid;
  logic              res_ready;
  pvlt_res_t         res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W:0]   ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W:0]   ram_rdata;

  pvlt_ctrl #(
    .SLOTS (SLOTS),
    .DATA_W(DATA_W),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (pvlt_op_e'(op_i)),
    .value_i    (value_i[DATA_W-1:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  pvlt_ram #(
    .WIDTH(DATA_W + 1),
    .DEPTH(SLOTS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pvlt_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_ready_o(res_ready),
    .res_i      (res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .occupancy_o(occupancy_o)
  );

endmodule

// ----- rtl/pvlt_checker.sv -----
`include "pooled_value_list_table_core_assert.svh"

module pvlt_checker import pvlt_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       status_o,
  input logic [OCC_W-1:0] occupancy_o
);

  // one item in flight at a time
  `PVLT_ASSERT(a_single_item, in_valid_i && in_ready_o |=> !in_ready_o, "second beat taken early")

  `PVLT_ASSERT(a_full_occ, out_valid_o && status_o == ST_FULL |-> occupancy_o == OCC_W'(SLOTS), "full without full count")

  `PVLT_NEVER(a_empty_occ, out_valid_o && status_o == ST_EMPTY && occupancy_o != '0, "empty with nonzero count")

  `PVLT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(occupancy_o), "stalled result beat changed")

endmodule

bind pooled_value_list_table_core pvlt_checker #(.SLOTS(SLOTS)) u_checker (.*);
